// ----- rtl/core/kpn_pkg.sv -----
// Shared types, protocol constants and lamp map for the keypad node responder.
package kpn_pkg;

  // Key scan width
  localparam int KEY_W = 24;

  // Number of stored frame slots
  localparam int FRAME_SLOTS = 5;

  // Input item codes
  localparam logic ITEM_BYTE = 1'b0;
  localparam logic ITEM_END  = 1'b1;

  // Result kinds
  localparam logic KIND_LAMP = 1'b0;
  localparam logic KIND_TX   = 1'b1;

  // Frame bytes
  localparam logic [7:0] FRAME_SOF    = 8'hFA;
  localparam logic [7:0] FRAME_EOF    = 8'hFF;
  localparam logic [7:0] REPLY_LAMP   = 8'hFB;
  localparam logic [7:0] REPLY_STATUS = 8'hFC;

  // Frame command codes
  localparam logic [7:0] CMD_LAMP   = 8'd1;
  localparam logic [7:0] CMD_STATUS = 8'd2;

  // Work queued for the reply side
  typedef enum logic {
    OP_LAMP,
    OP_STATUS
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [3:0]       addr;
    logic [4:0]       key;
    logic [KEY_W-1:0] keys;
  } job_t;

  // Lamp shift-register pattern for each key
  function automatic logic [KEY_W-1:0] lamp_map(input logic [4:0] key);
    logic [KEY_W-1:0] pat;
    begin
      case (key)
        5'd0:    pat = 24'h000001;
        5'd1:    pat = 24'h000080;
        5'd2:    pat = 24'h000040;
        5'd3:    pat = 24'h000020;
        5'd4:    pat = 24'h000010;
        5'd5:    pat = 24'h000008;
        5'd6:    pat = 24'h000004;
        5'd7:    pat = 24'h000002;
        5'd8:    pat = 24'h008000;
        5'd9:    pat = 24'h004000;
        5'd10:   pat = 24'h002000;
        5'd11:   pat = 24'h001000;
        5'd12:   pat = 24'h000800;
        5'd13:   pat = 24'h000400;
        5'd14:   pat = 24'h000200;
        5'd15:   pat = 24'h000100;
        5'd16:   pat = 24'h400000;
        5'd17:   pat = 24'h800000;
        5'd18:   pat = 24'h200000;
        5'd19:   pat = 24'h100000;
        5'd20:   pat = 24'h020000;
        5'd21:   pat = 24'h040000;
        5'd22:   pat = 24'h080000;
        5'd23:   pat = 24'h010000;
        default: pat = '0;
      endcase
      return pat;
    end
  endfunction

endpackage

// ----- rtl/core/kpn_front.sv -----
// Receive side: frame slot buffer, address check and command decode.
module kpn_front
  import kpn_pkg::*;
#(
  parameter int RX_DEPTH = 16,
  parameter int NUM_KEYS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             cmd,
  input  logic [7:0]       rx_byte,
  input  logic [KEY_W-1:0] key_states,
  input  logic             cfg_valid,
  input  logic [3:0]       node_address,
  input  logic             q_full,
  output logic             push,
  output job_t             push_job
);

  localparam int IDX_W = $clog2(RX_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(RX_DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_SLOTS = IDX_W'(FRAME_SLOTS);
  localparam logic [KEY_W-1:0] KEY_MASK =
    (NUM_KEYS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((32'd1 << NUM_KEYS) - 32'd1);
  localparam logic [7:0] KEY_LIMIT = 8'(NUM_KEYS);

  logic [7:0]       frame_bytes [FRAME_SLOTS];
  logic [IDX_W-1:0] write_index;
  logic [3:0]       node_addr;
  logic             accept;
  logic             frame_ok;
  logic             is_lamp;
  logic             is_status;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Frame check on the stored slots
  always_comb begin
    frame_ok  = (frame_bytes[0] == FRAME_SOF) && (frame_bytes[4] == FRAME_EOF) &&
                (frame_bytes[1] == {4'b0, node_addr});
    is_lamp   = frame_ok && (frame_bytes[2] == CMD_LAMP) && (frame_bytes[3] < KEY_LIMIT);
    is_status = frame_ok && (frame_bytes[2] == CMD_STATUS);
    push      = accept && (cmd == ITEM_END) && (is_lamp || is_status);
    push_job.op   = is_lamp ? OP_LAMP : OP_STATUS;
    push_job.addr = node_addr;
    push_job.key  = frame_bytes[3][4:0];
    push_job.keys = key_states & KEY_MASK;
  end

  // Address register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_addr <= '0;
    end else if (cfg_valid) begin
      node_addr <= node_address;
    end
  end

  // Write index wraps at the buffer depth; frame end rewinds it
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
    end else if (accept) begin
      if (cmd == ITEM_END || write_index == IDX_LAST) begin
        write_index <= '0;
      end else begin
        write_index <= write_index + 1'b1;
      end
    end
  end

  // Only the low slots are kept; later bytes fall off
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        frame_bytes[i] <= '0;
      end
    end else if (accept && cmd == ITEM_BYTE && write_index < IDX_SLOTS) begin
      frame_bytes[write_index[2:0]] <= rx_byte;
    end
  end

endmodule

// ----- rtl/core/kpn_queue.sv -----
// Two-entry job queue between the receive side and the reply side.
module kpn_queue
  import kpn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/kpn_back.sv -----
// Reply side: walks one job into its reply bytes, preceded by a lamp pattern for a lamp job.
module kpn_back
  import kpn_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  job_t             head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             kind,
  output logic [KEY_W-1:0] lamp_pattern,
  output logic [7:0]       tx_byte,
  output logic             last
);

  logic [2:0]       cnt;
  logic [2:0]       byte_idx;
  logic             is_lamp;
  logic             emit_pat;
  logic             key_state;
  logic [KEY_W-1:0] key_shift;
  logic [7:0]       res_byte;
  logic             res_last;
  logic             fire;

  // Pick the current result of the job at the queue head
  always_comb begin
    is_lamp   = (head.op == OP_LAMP);
    emit_pat  = is_lamp && (cnt == 3'd0);
    byte_idx  = is_lamp ? cnt - 3'd1 : cnt;
    key_shift = head.keys >> head.key;
    key_state = key_shift[0];
    case (byte_idx)
      3'd0:    res_byte = is_lamp ? REPLY_LAMP : REPLY_STATUS;
      3'd1:    res_byte = {4'b0, head.addr};
      3'd2:    res_byte = is_lamp ? CMD_LAMP : head.keys[23:16];
      3'd3:    res_byte = is_lamp ? {3'b0, head.key} : head.keys[15:8];
      3'd4:    res_byte = is_lamp ? {7'b0, key_state} : head.keys[7:0];
      default: res_byte = FRAME_EOF;
    endcase
    res_last = !emit_pat && (byte_idx == 3'd5);
    fire     = head_valid && (!out_valid || out_ready);
    pop      = fire && res_last;
  end

  // Step counter within the job
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (pop) begin
      cnt <= '0;
    end else if (fire) begin
      cnt <= cnt + 3'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      kind         <= emit_pat ? KIND_LAMP : KIND_TX;
      lamp_pattern <= emit_pat ? lamp_map(head.key) : '0;
      tx_byte      <= emit_pat ? 8'd0 : res_byte;
      last         <= res_last;
    end
  end

endmodule

// ----- rtl/core/keypad_node_frame_responder_core.sv -----
// Top level of the keypad node frame responder.
// Received bytes land in the first five slots of a wrapping receive index; a frame end
// is checked in the same cycle it is accepted and, when it carries a lamp or status
// command for this node, becomes a job in a two-entry queue. The reply side turns a
// job into seven results (lamp command) or six (status command), one per cycle while
// out_ready holds; new requests keep being accepted meanwhile and in_ready drops only
// while the job queue is full. Other frames give no results. The address register is
// written through cfg_valid and node_address and is always ready.
module keypad_node_frame_responder_core
  import kpn_pkg::*;
#(
  parameter int RX_DEPTH = 16,
  parameter int NUM_KEYS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             cmd,
  input  logic [7:0]       rx_byte,
  input  logic [KEY_W-1:0] key_states,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             kind,
  output logic [KEY_W-1:0] lamp_pattern,
  output logic [7:0]       tx_byte,
  output logic             last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [3:0]       node_address
);

  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  logic head_valid;
  job_t head;

  assign cfg_ready = 1'b1;

  kpn_front #(
    .RX_DEPTH (RX_DEPTH),
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .rx_byte      (rx_byte),
    .key_states   (key_states),
    .cfg_valid    (cfg_valid),
    .node_address (node_address),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  kpn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  kpn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .lamp_pattern (lamp_pattern),
    .tx_byte      (tx_byte),
    .last         (last)
  );

endmodule

// ----- rtl/core/kpn_checker.sv -----
// Port-level checks for the keypad node frame responder, bound to the top level.
module kpn_checker
  import kpn_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic             kind,
  input logic [KEY_W-1:0] lamp_pattern,
  input logic [7:0]       tx_byte,
  input logic             last
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(lamp_pattern))
    else $error("result changed while stalled");

  // A lamp result lights exactly one lamp and never ends a run
  a_lamp_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_LAMP |-> $onehot(lamp_pattern) && tx_byte == 8'd0 && !last)
    else $error("malformed lamp result");

  // Reply bytes carry no lamp pattern
  a_tx_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_TX |-> lamp_pattern == '0)
    else $error("reply byte with lamp pattern");

  // Every reply run closes with the end byte
  a_last_eof: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> kind == KIND_TX && tx_byte == FRAME_EOF)
    else $error("reply run not closed by end byte");

endmodule

bind keypad_node_frame_responder_core kpn_checker u_kpn_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .lamp_pattern (lamp_pattern),
  .tx_byte      (tx_byte),
  .last         (last)
);
